// ===== sv/nfm_pkg.sv =====
// ----------------------------------------------------------------------------
// nfm_pkg
// Shared types and constants for the palette nearest/farthest match unit.
// ----------------------------------------------------------------------------
package nfm_pkg;

   localparam int OP_W     = 2;
   localparam int IDX_IN_W = 4;
   localparam int COLOR_W  = 12;
   localparam int DIST_W   = 9;
   localparam int MATCH_W  = 4;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;

   localparam int BLUE_LSB  = 0;
   localparam int BLUE_W    = 3;
   localparam int GREEN_LSB = 4;
   localparam int GREEN_W   = 3;
   localparam int RED_LSB   = 8;
   localparam int RED_W     = 4;

   localparam logic [DIST_W-1:0] DIST_MAX = 9'd323;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE    = 2'd0,
      OP_CLOSEST  = 2'd1,
      OP_FARTHEST = 2'd2
   } op_type;

   typedef struct packed {
      logic vld;
      logic first;
      logic last;
   } scan_tag_type;

endpackage

// ===== sv/palette_nearest_farthest_match_unit.sv =====
// ----------------------------------------------------------------------------
// palette_nearest_farthest_match_unit
// Palette store with closest-color and farthest-color search.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one transaction per operation: palette write, closest
//   query (color and start index) or farthest query (reference entry index).
//   rsp channel returns one transaction per query (match index and distance);
//   writes and the unused operation code return nothing.
// Scan:
//   A closest query scans from its start index to the last entry, a farthest
//   query first loads its reference entry and then scans every entry. The
//   scan reads one palette entry per cycle through the single memory read
//   port into one shared distance unit, and req_tready stays low from query
//   acceptance until its result is loaded.
// Reset:
//   All palette entries read as zero, the sequencer returns to idle and any
//   pending result is dropped.
// Stall:
//   The result waits in the output register while rsp_tready is low; the
//   next request is taken meanwhile, and a second query holds until it frees.
// ----------------------------------------------------------------------------
module palette_nearest_farthest_match_unit
   import nfm_pkg::*;
#(
   parameter int PALETTE_ENTRIES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // operation, entry_index, color_value, zero pad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // match_index, match_distance, zero pad
);

   localparam int IDX_W  = $clog2(PALETTE_ENTRIES);
   localparam int WIDE_W = ((IDX_W > IDX_IN_W) ? IDX_W : IDX_IN_W) + 1;
   localparam logic [WIDE_W-1:0] ENTRIES_WIDE = WIDE_W'(PALETTE_ENTRIES);
   localparam logic [IDX_W-1:0]  LAST_IDX     = IDX_W'(PALETTE_ENTRIES - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REF_LOAD,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   addr_ff, addr_in;
   logic               first_ff, first_in;
   logic               closest_ff, closest_in;
   logic [COLOR_W-1:0] target_ff, target_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic [DIST_W-1:0]  best_dist_ff, best_dist_in;
   scan_tag_type       tag1_ff, tag1_in;
   logic [IDX_W-1:0]   idx1_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [MATCH_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [DIST_W-1:0]  rsp_dist_ff, rsp_dist_in;

   op_type             in_op;
   logic [IDX_IN_W-1:0] in_idx;
   logic [COLOR_W-1:0] in_color;
   logic [WIDE_W-1:0]  in_idx_wide;
   logic               in_in_range;
   logic [IDX_W-1:0]   in_clamped;
   logic               req_fire;
   logic               wr_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [COLOR_W-1:0] rd_data;
   logic [DIST_W-1:0]  dist_value;
   scan_tag_type       dist_tag;
   logic [IDX_W-1:0]   dist_idx;
   logic               take;
   logic [WIDE_W-1:0]  best_idx_wide;

   assign in_op       = op_type'(req_tdata[OP_W-1:0]);
   assign in_idx      = req_tdata[OP_W +: IDX_IN_W];
   assign in_color    = req_tdata[OP_W + IDX_IN_W +: COLOR_W];
   assign in_idx_wide = WIDE_W'(in_idx);
   assign in_in_range = (in_idx_wide < ENTRIES_WIDE);
   assign in_clamped  = in_in_range ? in_idx_wide[IDX_W-1:0] : LAST_IDX;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign wr_en      = req_fire && (in_op == OP_WRITE) && in_in_range;
   assign rd_addr    = (state_ff == ST_IDLE) ? in_clamped : addr_ff;

   nfm_palette_mem #(
      .ENTRIES (PALETTE_ENTRIES),
      .IDX_W   (IDX_W)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (in_clamped),
      .wr_data (in_color),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   nfm_dist_unit #(
      .IDX_W (IDX_W)
   ) u_dist (
      .clock    (clock),
      .reset    (reset),
      .a_color  (target_ff),
      .b_color  (rd_data),
      .in_tag   (tag1_ff),
      .in_idx   (idx1_ff),
      .out_dist (dist_value),
      .out_tag  (dist_tag),
      .out_idx  (dist_idx)
   );

   assign take = dist_tag.first ||
                 (closest_ff ? (dist_value < best_dist_ff) : (dist_value > best_dist_ff));
   assign best_idx_wide = WIDE_W'(best_idx_ff);

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      first_in     = first_ff;
      closest_in   = closest_ff;
      target_in    = target_ff;
      best_idx_in  = best_idx_ff;
      best_dist_in = best_dist_ff;
      tag1_in      = '0;
      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_dist_in  = rsp_dist_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (dist_tag.vld && take) begin
         best_idx_in  = dist_idx;
         best_dist_in = dist_value;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (in_op)
                  OP_CLOSEST: begin
                     closest_in = 1'b1;
                     target_in  = in_color;
                     addr_in    = in_clamped;
                     first_in   = 1'b1;
                     state_in   = ST_SCAN;
                  end
                  OP_FARTHEST: begin
                     closest_in = 1'b0;
                     addr_in    = '0;
                     first_in   = 1'b1;
                     state_in   = ST_REF_LOAD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_REF_LOAD, ST_SCAN: begin
            if (state_ff == ST_REF_LOAD) begin
               target_in = rd_data;
            end
            tag1_in.vld   = 1'b1;
            tag1_in.first = first_ff;
            tag1_in.last  = (addr_ff == LAST_IDX);
            first_in      = 1'b0;
            if (addr_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end else begin
               addr_in  = addr_ff + IDX_W'(1);
               state_in = ST_SCAN;
            end
         end
         ST_DRAIN: begin
            if (dist_tag.vld && dist_tag.last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = best_idx_wide[MATCH_W-1:0];
               rsp_dist_in  = best_dist_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tag1_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tag1_ff      <= tag1_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff      <= addr_in;
      first_ff     <= first_in;
      closest_ff   <= closest_in;
      target_ff    <= target_in;
      best_idx_ff  <= best_idx_in;
      best_dist_ff <= best_dist_in;
      idx1_ff      <= addr_ff;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_dist_ff  <= rsp_dist_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - MATCH_W - DIST_W){1'b0}}, rsp_dist_ff, rsp_idx_ff};

`ifndef SYNTHESIS
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!tag1_ff.vld && !dist_tag.vld))
      else $error("scan pipeline busy while idle");

   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_dist_ff <= DIST_MAX))
      else $error("match distance out of range");

   a_last_ends_scan: assert property (@(posedge clock) disable iff (reset)
      (tag1_ff.vld && tag1_ff.last) |=> !tag1_ff.vld)
      else $error("entry issued after last entry of scan");

   a_first_loads_best: assert property (@(posedge clock) disable iff (reset)
      (dist_tag.vld && dist_tag.first) |=>
         ((best_dist_ff == $past(dist_value)) && (best_idx_ff == $past(dist_idx))))
      else $error("first scanned entry did not seed the best match");
`endif

endmodule

// ===== sv/nfm_palette_mem.sv =====
// ----------------------------------------------------------------------------
// nfm_palette_mem
// Palette storage: one write port, one registered read port, and per-entry
// valid bits so that unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module nfm_palette_mem
   import nfm_pkg::*;
#(
   parameter int ENTRIES = 16,
   parameter int IDX_W   = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [IDX_W-1:0]   wr_addr,
   input  logic [COLOR_W-1:0] wr_data,
   input  logic [IDX_W-1:0]   rd_addr,
   output logic [COLOR_W-1:0] rd_data
);

   logic [COLOR_W-1:0] palette_ff [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   logic [COLOR_W-1:0] rd_data_ff;
   logic               rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         palette_ff[wr_addr] <= wr_data;
      end
      rd_data_ff  <= palette_ff[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ===== sv/nfm_dist_unit.sv =====
// ----------------------------------------------------------------------------
// nfm_dist_unit
// Shared color distance unit: sum of squared channel differences, registered,
// with the scan tag and entry index carried alongside.
// ----------------------------------------------------------------------------
module nfm_dist_unit
   import nfm_pkg::*;
#(
   parameter int IDX_W = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [COLOR_W-1:0] a_color,
   input  logic [COLOR_W-1:0] b_color,
   input  scan_tag_type       in_tag,
   input  logic [IDX_W-1:0]   in_idx,
   output logic [DIST_W-1:0]  out_dist,
   output scan_tag_type       out_tag,
   output logic [IDX_W-1:0]   out_idx
);

   logic [BLUE_W-1:0]    a_blue, b_blue, d_blue;
   logic [GREEN_W-1:0]   a_green, b_green, d_green;
   logic [RED_W-1:0]     a_red, b_red, d_red;
   logic [2*BLUE_W-1:0]  sq_blue;
   logic [2*GREEN_W-1:0] sq_green;
   logic [2*RED_W-1:0]   sq_red;
   logic [DIST_W-1:0]    dist_in, dist_ff;
   scan_tag_type         tag_ff;
   logic [IDX_W-1:0]     idx_ff;

   always_comb begin
      a_blue   = a_color[BLUE_LSB +: BLUE_W];
      b_blue   = b_color[BLUE_LSB +: BLUE_W];
      a_green  = a_color[GREEN_LSB +: GREEN_W];
      b_green  = b_color[GREEN_LSB +: GREEN_W];
      a_red    = a_color[RED_LSB +: RED_W];
      b_red    = b_color[RED_LSB +: RED_W];
      d_blue   = (a_blue  >= b_blue)  ? (a_blue  - b_blue)  : (b_blue  - a_blue);
      d_green  = (a_green >= b_green) ? (a_green - b_green) : (b_green - a_green);
      d_red    = (a_red   >= b_red)   ? (a_red   - b_red)   : (b_red   - a_red);
      sq_blue  = (2*BLUE_W)'(d_blue) * (2*BLUE_W)'(d_blue);
      sq_green = (2*GREEN_W)'(d_green) * (2*GREEN_W)'(d_green);
      sq_red   = (2*RED_W)'(d_red) * (2*RED_W)'(d_red);
      dist_in  = DIST_W'(sq_blue) + DIST_W'(sq_green) + DIST_W'(sq_red);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= in_tag;
      end
      dist_ff <= dist_in;
      idx_ff  <= in_idx;
   end

   assign out_dist = dist_ff;
   assign out_tag  = tag_ff;
   assign out_idx  = idx_ff;

endmodule

// ===== bench/tb_palette_nearest_farthest_match_unit.sv =====
// ----------------------------------------------------------------------------
// tb_palette_nearest_farthest_match_unit
// Self-checking bench for the palette closest/farthest color search.
// ----------------------------------------------------------------------------
// A local palette copy tracks every accepted write, and each accepted query is
// scored against it to form the expected match index and distance. Directed
// transactions cover the color extremes, ties, the largest distance, the
// unused operation and the ignored color of a farthest query. Random phases
// then run with no idling, with the sender idle, with the receiver stalling,
// and with both. A long receiver hold-off fills the block, and a drain pause
// lets every pending result return before traffic resumes.
// ----------------------------------------------------------------------------
module tb_palette_nearest_farthest_match_unit;
   import nfm_pkg::*;

   localparam int          ENTRIES      = 16;
   localparam logic [1:0]  OP_UNUSED    = 2'd3;
   localparam int          SETTLE_CYCLES = ENTRIES + 10;
   localparam int          LIMIT_CYCLES = 400000;

   typedef struct packed {
      logic [MATCH_W-1:0] index;
      logic [DIST_W-1:0]  distance;
   } match_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // operation, entry_index, color_value, zero pad
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // match_index, match_distance, zero pad

   logic [COLOR_W-1:0] palette_copy [ENTRIES];
   match_type          pending_matches [$];
   int                 send_idle_pct = 0;
   int                 rsp_stall_pct = 0;
   int                 hold_left     = 0;
   int                 n_fail        = 0;
   int                 cycle_count   = 0;

   palette_nearest_farthest_match_unit #(
      .PALETTE_ENTRIES(ENTRIES)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int unsigned color_dist(logic [COLOR_W-1:0] a, logic [COLOR_W-1:0] b);
      int db;
      int dg;
      int dr;
      db = int'(a[BLUE_LSB +: BLUE_W]) - int'(b[BLUE_LSB +: BLUE_W]);
      dg = int'(a[GREEN_LSB +: GREEN_W]) - int'(b[GREEN_LSB +: GREEN_W]);
      dr = int'(a[RED_LSB +: RED_W]) - int'(b[RED_LSB +: RED_W]);
      return db * db + dg * dg + dr * dr;
   endfunction

   // apply one accepted transaction to the palette copy and queue its match
   task automatic score_transaction(logic [OP_W-1:0] op, logic [IDX_IN_W-1:0] idx,
                                    logic [COLOR_W-1:0] color);
      int unsigned best_dist;
      int unsigned d;
      int          best_idx;
      logic [COLOR_W-1:0] ref_color;
      match_type   m;
      if (op == OP_WRITE) begin
         palette_copy[idx] = color;
      end else if (op == OP_CLOSEST) begin
         best_idx  = idx;
         best_dist = color_dist(color, palette_copy[idx]);
         for (int i = idx + 1; i < ENTRIES; i++) begin
            d = color_dist(color, palette_copy[i]);
            if (d < best_dist) begin
               best_dist = d;
               best_idx  = i;
            end
         end
      end else if (op == OP_FARTHEST) begin
         ref_color = palette_copy[idx];
         best_idx  = 0;
         best_dist = color_dist(ref_color, palette_copy[0]);
         for (int i = 1; i < ENTRIES; i++) begin
            d = color_dist(ref_color, palette_copy[i]);
            if (d > best_dist) begin
               best_dist = d;
               best_idx  = i;
            end
         end
      end
      if (op == OP_CLOSEST || op == OP_FARTHEST) begin
         m.index    = best_idx[MATCH_W-1:0];
         m.distance = best_dist[DIST_W-1:0];
         pending_matches.push_back(m);
      end
   endtask

   task automatic send_item(logic [OP_W-1:0] op, logic [IDX_IN_W-1:0] idx,
                            logic [COLOR_W-1:0] color);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, color, idx, op};
      do @(posedge clock); while (!req_tready);
      score_transaction(op, idx, color);
   endtask

   task automatic send_random_item(bit queries_only);
      int                 r;
      logic [OP_W-1:0]    op;
      logic [COLOR_W-1:0] color;
      r = queries_only ? 40 + $urandom_range(55) : $urandom_range(99);
      if (r < 40)
         op = OP_WRITE;
      else if (r < 68)
         op = OP_CLOSEST;
      else if (r < 96)
         op = OP_FARTHEST;
      else
         op = OP_UNUSED;
      // reuse stored colors often so ties show up
      if ($urandom_range(2) == 0)
         color = palette_copy[IDX_IN_W'($urandom_range(ENTRIES - 1))];
      else
         color = COLOR_W'($urandom_range(4095));
      send_item(op, IDX_IN_W'($urandom_range(ENTRIES - 1)), color);
   endtask

   task automatic set_phase(int idle_pct, int stall_pct);
      @(negedge clock);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      wait (pending_matches.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_directed();
      set_phase(0, 0);
      // reset palette: all ties at distance zero
      send_item(OP_CLOSEST, 4'd0, 12'h000);
      send_item(OP_FARTHEST, 4'd15, 12'hFFF);
      send_item(OP_CLOSEST, 4'd15, 12'hF77);
      send_item(OP_WRITE, 4'd0, 12'hF77);
      send_item(OP_WRITE, 4'd15, 12'hFFF);
      send_item(OP_WRITE, 4'd7, 12'h088);
      send_item(OP_WRITE, 4'd8, 12'h808);
      send_item(OP_CLOSEST, 4'd0, 12'h000);
      send_item(OP_CLOSEST, 4'd0, 12'hF77);
      send_item(OP_CLOSEST, 4'd1, 12'hF77);
      send_item(OP_CLOSEST, 4'd15, 12'h000);
      send_item(OP_FARTHEST, 4'd0, 12'h000);
      send_item(OP_FARTHEST, 4'd15, 12'hABC);
      send_item(OP_FARTHEST, 4'd7, 12'hFFF);
      send_item(OP_UNUSED, 4'd15, 12'hFFF);
      send_item(OP_UNUSED, 4'd0, 12'h000);
      send_item(OP_WRITE, 4'd3, 12'h777);
      send_item(OP_CLOSEST, 4'd2, 12'h777);
      send_item(OP_FARTHEST, 4'd3, 12'h555);
      send_item(OP_WRITE, 4'd15, 12'h000);
      send_item(OP_CLOSEST, 4'd9, 12'h0F0);
      send_item(OP_FARTHEST, 4'd1, 12'h3A5);
      drain_results();
   endtask

   task automatic test_random_phase(int n, int idle_pct, int stall_pct);
      set_phase(idle_pct, stall_pct);
      repeat (n) send_random_item(1'b0);
      drain_results();
   endtask

   task automatic test_receiver_hold();
      set_phase(0, 0);
      @(negedge clock);
      hold_left = 300;
      repeat (12) send_random_item(1'b1);
      drain_results();
   endtask

   task automatic test_drain_pause();
      set_phase(20, 20);
      repeat (10) send_random_item(1'b0);
      drain_results();
      repeat (10) send_random_item(1'b0);
      drain_results();
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      match_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_matches.size() == 0) begin
            $error("unexpected result transaction: match_index %0d match_distance %0d",
                   rsp_tdata[3:0], rsp_tdata[12:4]);
            n_fail++;
         end else begin
            want = pending_matches.pop_front();
            if (rsp_tdata[3:0] !== want.index) begin
               $error("match_index: expected %0d, got %0d", want.index, rsp_tdata[3:0]);
               n_fail++;
            end
            if (rsp_tdata[12:4] !== want.distance) begin
               $error("match_distance: expected %0d, got %0d", want.distance,
                      rsp_tdata[12:4]);
               n_fail++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("palette_nearest_farthest_match_unit regression: fail");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < ENTRIES; i++) palette_copy[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_phase(160, 0, 0);
      test_random_phase(160, 55, 0);
      test_random_phase(160, 0, 55);
      test_random_phase(160, 32, 32);
      test_receiver_hold();
      test_drain_pause();
      if (n_fail == 0)
         $display("palette_nearest_farthest_match_unit regression: pass");
      else
         $display("palette_nearest_farthest_match_unit regression: fail");
      $finish;
   end

endmodule
